>>> hdl/hcs_pkg.sv
// ----------------------------------------------------------------------------
// Hermite curve sampler package
// Shared constants and the sequencer state type of the curve sampler.
// ----------------------------------------------------------------------------
package hcs_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int MAX_STEPS_DEF  = 63;
   localparam int CFG_BITS       = 6;

   localparam logic [CFG_BITS-1:0] SPS_RESET = CFG_BITS'(16);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_WGT,
      ST_MAC,
      ST_PREP,
      ST_DIV,
      ST_FIN,
      ST_EMIT
   } hcs_state_type;

endpackage

>>> hdl/hcs_point_if.sv
// ----------------------------------------------------------------------------
// Control point channel
// Valid/ready channel that carries one control point and its restart flag.
// ----------------------------------------------------------------------------
interface hcs_point_if import hcs_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) ();

   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;
   logic signed [COORD_BITS-1:0] point_z;
   logic                         start_curve;

   modport source (
      output valid, point_x, point_y, point_z, start_curve,
      input  ready
   );

   modport sink (
      input  valid, point_x, point_y, point_z, start_curve,
      output ready
   );

endinterface

>>> hdl/hcs_sample_if.sv
// ----------------------------------------------------------------------------
// Curve sample channel
// Valid/ready channel that carries one sampled curve point.
// ----------------------------------------------------------------------------
interface hcs_sample_if import hcs_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) ();

   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] curve_x;
   logic signed [COORD_BITS-1:0] curve_y;
   logic signed [COORD_BITS-1:0] curve_z;
   logic                         segment_end;

   modport source (
      output valid, curve_x, curve_y, curve_z, segment_end,
      input  ready
   );

   modport sink (
      input  valid, curve_x, curve_y, curve_z, segment_end,
      output ready
   );

endinterface

>>> hdl/hermite_curve_sampler_top.sv
// ----------------------------------------------------------------------------
// Hermite curve sampler
// Collects chained control points and emits N+1 cubic Hermite samples per
// completed segment, using one shared multiplier and a restoring divider.
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  req_ch    in         point_x/y/z (signed Q8.8), start_curve
//  rsp_ch    out        curve_x/y/z (signed Q8.8, saturated), segment_end
//  csr_*     in         samples_per_segment (6 bits), write only
//
// A point that does not complete a segment is only stored. A completing point
// starts the setup steps that form N^2 and N^3; each sample then takes 5 weight
// steps, per coordinate 5 multiply-accumulate steps on the shared multiplier and
// COORD_BITS+2 steps of the divider by 2*N^3, and one emit step. Reset is
// synchronous; the point store is not cleared. A stalled sample holds the
// sequencer in its emit step; the last sample of a segment frees req_ch.
// ----------------------------------------------------------------------------
module hermite_curve_sampler_top import hcs_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int MAX_STEPS  = MAX_STEPS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [CFG_BITS-1:0] csr_wr_data,
   hcs_point_if.sink           req_ch,
   hcs_sample_if.source        rsp_ch
);

   localparam int CB    = COORD_BITS;
   localparam int SB    = $clog2(MAX_STEPS + 1);
   localparam int DB    = 3 * SB;
   localparam int WB    = DB + 3;
   localparam int AW    = (CB + 1 > 2 * SB + 1) ? CB + 1 : 2 * SB + 1;
   localparam int PW    = AW + WB;
   localparam int ACC_W = PW + 2;
   localparam int NW    = ACC_W + 2;
   localparam int CNTW  = $clog2(CB);

   localparam logic [CB-1:0] Q_HI  = {1'b0, {(CB-1){1'b1}}};
   localparam logic [CB-1:0] Q_MID = {1'b1, {(CB-1){1'b0}}};

   hcs_state_type state_ff, state_in;

   logic [CFG_BITS-1:0] cfg_ff, cfg_in;
   logic                have_anchor_ff, have_anchor_in;
   logic [1:0]          held_ff, held_in;

   logic signed [CB-1:0] p0_ff [3], p0_in [3];
   logic signed [CB-1:0] h0_ff [3], h0_in [3];
   logic signed [CB-1:0] h1_ff [3], h1_in [3];
   logic signed [CB-1:0] p1_ff [3], p1_in [3];
   logic signed [CB-1:0] pt [3];

   logic [SB-1:0]   n_ff, n_in, k_ff, k_in, n_clamp;
   logic [2*SB-1:0] n2_ff, n2_in, k2_ff, k2_in;
   logic [DB-1:0]   d_ff, d_in, k3_ff, k3_in, k2n_ff, k2n_in, kn2_ff, kn2_in;
   logic signed [WB-1:0] w_ff [4], w_in [4];
   logic signed [WB-1:0] e3, e2n, en2, ed;

   logic [2:0] step_ff, step_in;
   logic [1:0] crd_ff, crd_in;

   logic signed [AW-1:0]    mul_a;
   logic signed [WB-1:0]    mul_b;
   logic signed [PW-1:0]    mul_p;
   logic signed [PW-1:0]    prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [CB:0]      term;

   logic [ACC_W-1:0] mag;
   logic [NW-1:0]    num, den2;
   logic [NW-1:0]    rem_ff, rem_in, dsh_ff, dsh_in;
   logic [CB-1:0]    quo_ff, quo_in, sat_val;
   logic [CNTW-1:0]  bit_ff, bit_in;
   logic             neg_ff, neg_in, ovf_ff, ovf_in, ge;

   logic signed [CB-1:0] samp_ff [3], samp_in [3];

   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [CB-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in, rsp_z_ff, rsp_z_in;
   logic                 rsp_end_ff, rsp_end_in;

   logic req_xfer;

   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign req_xfer           = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.curve_x     = rsp_x_ff;
   assign rsp_ch.curve_y     = rsp_y_ff;
   assign rsp_ch.curve_z     = rsp_z_ff;
   assign rsp_ch.segment_end = rsp_end_ff;

   assign pt[0] = req_ch.point_x;
   assign pt[1] = req_ch.point_y;
   assign pt[2] = req_ch.point_z;

   // N of zero behaves as one; values above the supported maximum are capped.
   always_comb begin
      if (cfg_ff == '0) begin
         n_clamp = SB'(1);
      end else if (int'(cfg_ff) > MAX_STEPS) begin
         n_clamp = SB'(MAX_STEPS);
      end else begin
         n_clamp = SB'(cfg_ff);
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      case (step_ff[1:0])
         2'd0:    term = (CB+1)'(p0_ff[crd_ff]);
         2'd1:    term = (CB+1)'(p1_ff[crd_ff]);
         2'd2:    term = (CB+1)'(h0_ff[crd_ff]) - (CB+1)'(p0_ff[crd_ff]);
         default: term = (CB+1)'(h1_ff[crd_ff]) - (CB+1)'(p1_ff[crd_ff]);
      endcase
   end

   always_comb begin
      mul_a = AW'(term);
      mul_b = w_ff[step_ff[1:0]];
      case (state_ff)
         ST_SETUP: begin
            if (step_ff == 3'd0) begin
               mul_a = AW'(n_ff);
            end else begin
               mul_a = AW'(n2_ff);
            end
            mul_b = WB'(n_ff);
         end
         ST_WGT: begin
            case (step_ff)
               3'd0: begin
                  mul_a = AW'(k_ff);
                  mul_b = WB'(k_ff);
               end
               3'd1: begin
                  mul_a = AW'(k2_ff);
                  mul_b = WB'(k_ff);
               end
               3'd2: begin
                  mul_a = AW'(k2_ff);
                  mul_b = WB'(n_ff);
               end
               default: begin
                  mul_a = AW'(n2_ff);
                  mul_b = WB'(k_ff);
               end
            endcase
         end
         default: begin
            mul_a = AW'(term);
            mul_b = w_ff[step_ff[1:0]];
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   assign e3  = WB'(k3_ff);
   assign e2n = WB'(k2n_ff);
   assign en2 = WB'(kn2_ff);
   assign ed  = WB'(d_ff);

   // Rounded magnitude numerator (2|s| + D) against the doubled divisor 2D.
   assign mag  = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign den2 = NW'({d_ff, 1'b0});
   assign num  = (NW'(mag) << 1) + NW'(d_ff);
   assign ge   = (rem_ff >= dsh_ff);

   always_comb begin
      if (!neg_ff) begin
         sat_val = (ovf_ff || quo_ff > Q_HI) ? Q_HI : quo_ff;
      end else begin
         sat_val = (ovf_ff || quo_ff > Q_MID) ? Q_MID : CB'(-quo_ff);
      end
   end

   always_comb begin
      state_in       = state_ff;
      cfg_in         = csr_wr_en ? csr_wr_data : cfg_ff;
      have_anchor_in = have_anchor_ff;
      held_in        = held_ff;
      p0_in          = p0_ff;
      h0_in          = h0_ff;
      h1_in          = h1_ff;
      p1_in          = p1_ff;
      n_in           = n_ff;
      n2_in          = n2_ff;
      d_in           = d_ff;
      k_in           = k_ff;
      k2_in          = k2_ff;
      k3_in          = k3_ff;
      k2n_in         = k2n_ff;
      kn2_in         = kn2_ff;
      w_in           = w_ff;
      step_in        = step_ff;
      crd_in         = crd_ff;
      prod_in        = prod_ff;
      acc_in         = acc_ff;
      rem_in         = rem_ff;
      dsh_in         = dsh_ff;
      quo_in         = quo_ff;
      bit_in         = bit_ff;
      neg_in         = neg_ff;
      ovf_in         = ovf_ff;
      samp_in        = samp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_z_in       = rsp_z_ff;
      rsp_end_in     = rsp_end_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_ch.start_curve || !have_anchor_ff) begin
                  p0_in          = pt;
                  have_anchor_in = 1'b1;
                  held_in        = 2'd0;
               end else begin
                  case (held_ff)
                     2'd0: begin
                        h0_in   = pt;
                        held_in = 2'd1;
                     end
                     2'd1: begin
                        h1_in   = pt;
                        held_in = 2'd2;
                     end
                     default: begin
                        p1_in    = pt;
                        held_in  = 2'd0;
                        n_in     = n_clamp;
                        step_in  = 3'd0;
                        state_in = ST_SETUP;
                     end
                  endcase
               end
            end
         end
         ST_SETUP: begin
            if (step_ff == 3'd0) begin
               n2_in   = mul_p[2*SB-1:0];
               step_in = 3'd1;
            end else begin
               d_in     = mul_p[DB-1:0];
               k_in     = '0;
               step_in  = 3'd0;
               state_in = ST_WGT;
            end
         end
         ST_WGT: begin
            step_in = step_ff + 3'd1;
            case (step_ff)
               3'd0: k2_in  = mul_p[2*SB-1:0];
               3'd1: k3_in  = mul_p[DB-1:0];
               3'd2: k2n_in = mul_p[DB-1:0];
               3'd3: kn2_in = mul_p[DB-1:0];
               default: begin
                  // Basis weights scaled by N^3, in the order P0, P1, T0, T1.
                  w_in[0]  = ed + e3 + e3 - e2n - e2n - e2n;
                  w_in[1]  = e2n + e2n + e2n - e3 - e3;
                  w_in[2]  = e3 - e2n - e2n + en2;
                  w_in[3]  = e3 - e2n;
                  step_in  = 3'd0;
                  crd_in   = 2'd0;
                  state_in = ST_MAC;
               end
            endcase
         end
         ST_MAC: begin
            // The product lands in a register and is added in the following step.
            prod_in = mul_p;
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd0) begin
               acc_in = '0;
            end else begin
               acc_in = acc_ff + ACC_W'(prod_ff);
            end
            if (step_ff == 3'd4) begin
               step_in  = 3'd0;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            rem_in   = num;
            ovf_in   = (num >= (den2 << CB));
            dsh_in   = den2 << (CB - 1);
            neg_in   = acc_ff[ACC_W-1];
            quo_in   = '0;
            bit_in   = CNTW'(CB - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = ge ? rem_ff - dsh_ff : rem_ff;
            quo_in = {quo_ff[CB-2:0], ge};
            dsh_in = dsh_ff >> 1;
            if (bit_ff == '0) begin
               state_in = ST_FIN;
            end else begin
               bit_in = bit_ff - CNTW'(1);
            end
         end
         ST_FIN: begin
            samp_in[crd_ff] = $signed(sat_val);
            if (crd_ff == 2'd2) begin
               state_in = ST_EMIT;
            end else begin
               crd_in   = crd_ff + 2'd1;
               step_in  = 3'd0;
               state_in = ST_MAC;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = samp_ff[0];
               rsp_y_in     = samp_ff[1];
               rsp_z_in     = samp_ff[2];
               rsp_end_in   = (k_ff == n_ff);
               if (k_ff == n_ff) begin
                  // The closing endpoint anchors the next segment of the chain.
                  p0_in    = p1_ff;
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + SB'(1);
                  step_in  = 3'd0;
                  state_in = ST_WGT;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff         <= SPS_RESET;
         have_anchor_ff <= 1'b0;
         held_ff        <= 2'd0;
         rsp_valid_ff   <= 1'b0;
         step_ff        <= 3'd0;
         crd_ff         <= 2'd0;
         k_ff           <= '0;
         bit_ff         <= '0;
      end else begin
         cfg_ff         <= cfg_in;
         have_anchor_ff <= have_anchor_in;
         held_ff        <= held_in;
         rsp_valid_ff   <= rsp_valid_in;
         step_ff        <= step_in;
         crd_ff         <= crd_in;
         k_ff           <= k_in;
         bit_ff         <= bit_in;
      end
   end

   always_ff @(posedge clock) begin
      p0_ff    <= p0_in;
      h0_ff    <= h0_in;
      h1_ff    <= h1_in;
      p1_ff    <= p1_in;
      n_ff     <= n_in;
      n2_ff    <= n2_in;
      d_ff     <= d_in;
      k2_ff    <= k2_in;
      k3_ff    <= k3_in;
      k2n_ff   <= k2n_in;
      kn2_ff   <= kn2_in;
      w_ff     <= w_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      rem_ff   <= rem_in;
      dsh_ff   <= dsh_in;
      quo_ff   <= quo_in;
      neg_ff   <= neg_in;
      ovf_ff   <= ovf_in;
      samp_ff  <= samp_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
      rsp_z_ff <= rsp_z_in;
      rsp_end_ff <= rsp_end_in;
   end

endmodule
